>>> rtl/alab_pkg.sv
// ----------------------------------------------------------------------------
// alab_pkg
// shared widths, codes and types of the admission limiter
// ----------------------------------------------------------------------------
package alab_pkg;

    localparam int MAX_THREADS = 64;
    localparam int DELAY_BITS  = 24;
    localparam int TID_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int LIMIT_W     = 7;
    localparam int TICKET_W    = 20;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int SLEEPS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = DELAY_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DELAY_BITS-1:0] DELAY_MAX          = {DELAY_BITS{1'b1}};
    localparam logic [DELAY_BITS-1:0] BACKOFF_RESET      = DELAY_BITS'(10000);
    localparam logic [DELAY_BITS-1:0] MAX_SLEEP_RESET    = DELAY_BITS'(150000);
    localparam logic [DELAY_BITS-1:0] BACKOFF_FLOOR      = DELAY_BITS'(20);
    localparam logic [TICKET_W-1:0]   FREE_TICKETS_RESET = TICKET_W'(500);
    localparam logic [CNT_W-1:0]      CNT_MAX            = CNT_W'(MAX_THREADS);
    localparam logic [SLEEPS_W-1:0]   SLEEPS_MAX         = {SLEEPS_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_TRY_ENTER   = 2'd0,
        CMD_FORCE_ENTER = 2'd1,
        CMD_FORCE_EXIT  = 2'd2,
        CMD_RESERVED    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 2'd0,
        ST_WAIT    = 2'd1,
        ST_INTR    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_TRY,
        OP_FORCE_ENTER,
        OP_FORCE_EXIT,
        OP_NOP
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT        = 2'd0,
        CFG_MAX_SLEEP    = 2'd1,
        CFG_FREE_TICKETS = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [TID_W-1:0] tid;
        logic             intr;
    } req_word_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]    limit;
        logic [DELAY_BITS-1:0] max_sleep;
        logic [TICKET_W-1:0]   free_tickets;
    } cfg_t;

    typedef struct packed {
        logic                seated;
        logic                waiting;
        logic [SLEEPS_W-1:0] sleeps;
        logic [TICKET_W-1:0] tickets;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/alab_if.sv
// ----------------------------------------------------------------------------
// alab_if
// request and response channels of the admission limiter
// ----------------------------------------------------------------------------
interface alab_req_if;
    logic                        valid;
    logic                        ready;
    logic [alab_pkg::CMD_W-1:0]  command;
    logic [alab_pkg::TID_W-1:0]  thread_id;
    logic                        interrupted;
    logic                        is_replica_thread;

    modport source (output valid, command, thread_id, interrupted, is_replica_thread,
                    input ready);
    modport sink (input valid, command, thread_id, interrupted, is_replica_thread,
                  output ready);
endinterface

interface alab_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [alab_pkg::STATUS_W-1:0]  status;
    logic [alab_pkg::DELAY_BITS-1:0] sleep_us;
    logic [alab_pkg::TICKET_W-1:0]  tickets_given;
    logic [alab_pkg::CNT_W-1:0]     active_count;
    logic [alab_pkg::CNT_W-1:0]     waiting_count;

    modport source (output valid, status, sleep_us, tickets_given, active_count,
                    waiting_count, input ready);
    modport sink (input valid, status, sleep_us, tickets_given, active_count,
                  waiting_count, output ready);
endinterface

>>> rtl/alab_ram.sv
// ----------------------------------------------------------------------------
// alab_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module alab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/alab_front.sv
// ----------------------------------------------------------------------------
// alab_front
// accepts request words, classifies them and queues them for execution
// ----------------------------------------------------------------------------
module alab_front (
    input  logic                 clk,
    input  logic                 rst_n,
    alab_req_if.sink             req,
    output logic                 q_valid,
    output alab_pkg::req_word_t  q_word,
    input  logic                 q_pop
);

    localparam int PTR_W = (alab_pkg::QUEUE_DEPTH > 1) ? $clog2(alab_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(alab_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(alab_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(alab_pkg::QUEUE_DEPTH);

    alab_pkg::req_word_t word_reg [alab_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    alab_pkg::req_word_t cls_word;
    logic                push;

    // classify: force exit of a replica worker and the reserved code do nothing
    always_comb
    begin
        cls_word.tid  = req.thread_id;
        cls_word.intr = req.interrupted;
        case (alab_pkg::cmd_t'(req.command))
            alab_pkg::CMD_TRY_ENTER:   cls_word.op = alab_pkg::OP_TRY;
            alab_pkg::CMD_FORCE_ENTER: cls_word.op = alab_pkg::OP_FORCE_ENTER;
            alab_pkg::CMD_FORCE_EXIT:
                cls_word.op = req.is_replica_thread ? alab_pkg::OP_NOP
                                                    : alab_pkg::OP_FORCE_EXIT;
            default:                   cls_word.op = alab_pkg::OP_NOP;
        endcase
    end

    assign req.ready = (count_reg != QCNT_FULL);
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_word    = word_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            word_reg[wr_ptr_reg] <= cls_word;
        end
    end

endmodule

>>> rtl/alab_back.sv
// ----------------------------------------------------------------------------
// alab_back
// executes queued words against the shared counters and per-thread entries
// ----------------------------------------------------------------------------
module alab_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alab_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  alab_pkg::req_word_t  q_word,
    output logic                 q_pop,
    alab_rsp_if.source           rsp
);

    alab_pkg::back_state_t           state_reg, state_next;
    alab_pkg::req_word_t             cur_reg;
    logic [alab_pkg::CNT_W-1:0]      active_reg, active_next;
    logic [alab_pkg::CNT_W-1:0]      waiting_reg, waiting_next;
    logic [alab_pkg::DELAY_BITS-1:0] backoff_reg, backoff_next;
    logic [alab_pkg::MAX_THREADS-1:0] valid_reg;

    logic                            out_valid_reg, out_valid_next;
    alab_pkg::status_t               status_reg, status_next;
    logic [alab_pkg::DELAY_BITS-1:0] sleep_reg, sleep_next;
    logic [alab_pkg::TICKET_W-1:0]   tickets_reg;

    logic [alab_pkg::ENTRY_W-1:0]    ram_rdata;
    alab_pkg::entry_t                cur_entry, new_entry;
    logic [alab_pkg::SLEEPS_W-1:0]   sleeps_at_grant;
    logic                            adapt;
    logic                            settled;
    logic                            fire;

    alab_ram #(
        .WIDTH (alab_pkg::ENTRY_W),
        .DEPTH (alab_pkg::MAX_THREADS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (fire),
        .waddr (cur_reg.tid),
        .wdata (new_entry),
        .re    (q_pop),
        .raddr (q_word.tid),
        .rdata (ram_rdata)
    );

    assign q_pop = (state_reg == alab_pkg::BK_IDLE) && q_valid;
    assign fire  = (state_reg == alab_pkg::BK_EXEC) && (!out_valid_reg || rsp.ready);
    assign adapt = (cfg.max_sleep != '0);

    // entry never written reads as reset value
    assign cur_entry = valid_reg[cur_reg.tid] ? alab_pkg::entry_t'(ram_rdata) : '0;

    always_comb
    begin
        new_entry       = cur_entry;
        active_next     = active_reg;
        waiting_next    = waiting_reg;
        backoff_next    = backoff_reg;
        status_next     = alab_pkg::ST_NONE;
        sleep_next      = '0;
        sleeps_at_grant = '0;
        settled         = 1'b0;
        case (cur_reg.op)
            alab_pkg::OP_TRY:
            begin
                if (!cur_entry.seated)
                begin
                    // a retry first closes out the previous sleep
                    if (cur_entry.waiting)
                    begin
                        if (new_entry.sleeps != alab_pkg::SLEEPS_MAX)
                        begin
                            new_entry.sleeps = new_entry.sleeps + 1'b1;
                        end
                        if (adapt && new_entry.sleeps > 2'd1
                            && backoff_next != alab_pkg::DELAY_MAX)
                        begin
                            backoff_next = backoff_next + 1'b1;
                        end
                        if (cur_reg.intr)
                        begin
                            if (waiting_next != '0)
                            begin
                                waiting_next = waiting_next - 1'b1;
                            end
                            new_entry.waiting = 1'b0;
                            new_entry.sleeps  = '0;
                            status_next       = alab_pkg::ST_INTR;
                            settled           = 1'b1;
                        end
                    end
                    if (!settled)
                    begin
                        if (cfg.limit == '0)
                        begin
                            if (new_entry.waiting && waiting_next != '0)
                            begin
                                waiting_next = waiting_next - 1'b1;
                            end
                            new_entry.waiting = 1'b0;
                            new_entry.sleeps  = '0;
                            status_next       = alab_pkg::ST_GRANTED;
                        end
                        else if (32'(active_reg) < 32'(cfg.limit))
                        begin
                            sleeps_at_grant = new_entry.sleeps;
                            if (active_next != alab_pkg::CNT_MAX)
                            begin
                                active_next = active_next + 1'b1;
                            end
                            new_entry.seated  = 1'b1;
                            new_entry.tickets = cfg.free_tickets;
                            if (new_entry.waiting && waiting_next != '0)
                            begin
                                waiting_next = waiting_next - 1'b1;
                            end
                            new_entry.waiting = 1'b0;
                            new_entry.sleeps  = '0;
                            if (adapt)
                            begin
                                if (backoff_next > alab_pkg::BACKOFF_FLOOR
                                    && sleeps_at_grant == 2'd1)
                                begin
                                    backoff_next = backoff_next - 1'b1;
                                end
                                if (waiting_next == '0)
                                begin
                                    backoff_next = backoff_next >> 1;
                                end
                            end
                            status_next = alab_pkg::ST_GRANTED;
                        end
                        else
                        begin
                            if (!new_entry.waiting)
                            begin
                                new_entry.waiting = 1'b1;
                                new_entry.sleeps  = '0;
                                if (waiting_next != alab_pkg::CNT_MAX)
                                begin
                                    waiting_next = waiting_next + 1'b1;
                                end
                            end
                            sleep_next = backoff_next;
                            if (adapt && sleep_next > cfg.max_sleep)
                            begin
                                sleep_next   = cfg.max_sleep;
                                backoff_next = cfg.max_sleep;
                            end
                            status_next = alab_pkg::ST_WAIT;
                        end
                    end
                end
            end
            alab_pkg::OP_FORCE_ENTER:
            begin
                if (cfg.limit != '0)
                begin
                    if (new_entry.waiting && waiting_next != '0)
                    begin
                        waiting_next = waiting_next - 1'b1;
                    end
                    new_entry.waiting = 1'b0;
                    new_entry.sleeps  = '0;
                    if (!cur_entry.seated && active_next != alab_pkg::CNT_MAX)
                    begin
                        active_next = active_next + 1'b1;
                    end
                    new_entry.seated  = 1'b1;
                    new_entry.tickets = alab_pkg::TICKET_W'(1);
                    status_next       = alab_pkg::ST_GRANTED;
                end
            end
            alab_pkg::OP_FORCE_EXIT:
            begin
                if (cur_entry.seated)
                begin
                    new_entry.tickets = '0;
                    new_entry.seated  = 1'b0;
                    if (active_next != '0)
                    begin
                        active_next = active_next - 1'b1;
                    end
                    status_next = alab_pkg::ST_GRANTED;
                end
            end
            default:
            begin
                status_next = alab_pkg::ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alab_pkg::BK_IDLE: if (q_pop) state_next = alab_pkg::BK_EXEC;
            alab_pkg::BK_EXEC: if (fire)  state_next = alab_pkg::BK_IDLE;
            default:           state_next = alab_pkg::BK_IDLE;
        endcase
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alab_pkg::BK_IDLE;
            active_reg    <= '0;
            waiting_reg   <= '0;
            backoff_reg   <= alab_pkg::BACKOFF_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                active_reg             <= active_next;
                waiting_reg            <= waiting_next;
                backoff_reg            <= backoff_next;
                valid_reg[cur_reg.tid] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_word;
        end
        if (fire)
        begin
            status_reg  <= status_next;
            sleep_reg   <= sleep_next;
            tickets_reg <= new_entry.tickets;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.sleep_us      = sleep_reg;
    assign rsp.tickets_given = tickets_reg;
    assign rsp.active_count  = active_reg;
    assign rsp.waiting_count = waiting_reg;

    // counters stay within the thread count
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg <= alab_pkg::CNT_MAX) && (waiting_reg <= alab_pkg::CNT_MAX))
        else $error("shared counter above thread count");

    // a stalled response holds the executing word back
    a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alab_pkg::BK_EXEC && out_valid_reg && !rsp.ready)
        |=> (state_reg == alab_pkg::BK_EXEC))
        else $error("word left execute while response stalled");

    // only a must-wait response carries a delay
    a_sleep_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != alab_pkg::ST_WAIT) |-> (sleep_reg == '0))
        else $error("delay on a response that is not must-wait");

    // nothing is popped while a word is still executing
    a_no_pop_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == alab_pkg::BK_IDLE) ##1 (state_reg == alab_pkg::BK_EXEC))
        else $error("pop outside idle");

endmodule

>>> rtl/admission_limiter_adaptive_backoff_top.sv
// ----------------------------------------------------------------------------
// admission_limiter_adaptive_backoff_top
// admission limiter with adaptive backoff for client threads
// ----------------------------------------------------------------------------
//
//   channel  role    word
//   -------  ------  --------------------------------------------------------
//   req      sink    command, thread_id, interrupted, is_replica_thread
//   rsp      source  status, sleep_us, tickets_given, active_count,
//                    waiting_count
//   cfg      write   cfg_we, cfg_index, cfg_data
//
// in the execute side, popping a word reads its thread entry from the entry ram
// (registered read); the execute state then updates the entry and loads the
// response register, and holds while the last response is not yet taken
// the front queue holds 2 words, so the request side keeps accepting, until the
// queue is full, while a response waits to be taken or a word is executing
// reset is asynchronous; per-thread entries carry one valid flop each that
// reset clears, so there is no clearing pass and words are taken right away
// ----------------------------------------------------------------------------
module admission_limiter_adaptive_backoff_top (
    input  logic                             clk,
    input  logic                             rst_n,
    alab_req_if.sink                         req,
    alab_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [alab_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [alab_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [alab_pkg::LIMIT_W-1:0]    limit_reg;
    logic [alab_pkg::DELAY_BITS-1:0] max_sleep_reg;
    logic [alab_pkg::TICKET_W-1:0]   free_tickets_reg;
    alab_pkg::cfg_t                  cfg;

    // queue between front and back
    logic                            q_valid;
    alab_pkg::req_word_t             q_word;
    logic                            q_pop;

    // writes beyond the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg        <= '0;
            max_sleep_reg    <= alab_pkg::MAX_SLEEP_RESET;
            free_tickets_reg <= alab_pkg::FREE_TICKETS_RESET;
        end
        else if (cfg_we)
        begin
            case (alab_pkg::cfg_idx_t'(cfg_index))
                alab_pkg::CFG_LIMIT:
                    limit_reg <= cfg_data[alab_pkg::LIMIT_W-1:0];
                alab_pkg::CFG_MAX_SLEEP:
                    max_sleep_reg <= cfg_data[alab_pkg::DELAY_BITS-1:0];
                alab_pkg::CFG_FREE_TICKETS:
                    free_tickets_reg <= cfg_data[alab_pkg::TICKET_W-1:0];
                default:
                begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    assign cfg.limit        = limit_reg;
    assign cfg.max_sleep    = max_sleep_reg;
    assign cfg.free_tickets = free_tickets_reg;

    // front: accept, classify and queue
    alab_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop)
    );

    // back: execute against counters and per-thread entries
    alab_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
